// ===== design/auh_pkg.sv =====
// Shared types and constants for the autoscaling uniform histogram.
// Used by the controller, the datapath and the top level; no dependencies.
package auh_pkg;

  localparam int LOW_BITS   = 48;
  localparam int WIDTH_BITS = 43;
  localparam int RESC_BITS  = 16;
  localparam int ADDR_BITS  = 4;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [1:0] REG_START_LOW   = 2'd0;
  localparam logic [1:0] REG_START_WIDTH = 2'd1;
  localparam logic [1:0] REG_AUTO_SCALE  = 2'd2;

  localparam logic signed [31:0] START_LOW_RST   = 32'sd0;
  localparam logic [31:0]        START_WIDTH_RST = 32'd1;
  localparam logic               AUTO_SCALE_RST  = 1'b1;

  // doubling stops once the width would pass 2^42 or low would pass -2^47
  localparam logic [WIDTH_BITS-1:0]      WIDTH_HALF = 43'h200_0000_0000;
  localparam logic signed [LOW_BITS-1:0] LOW_MIN    = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] sample;
    logic [5:0]         read_index;
  } auh_in_t;

  typedef struct packed {
    logic [5:0]                  bin_index;
    logic [31:0]                 bin_count;
    logic signed [LOW_BITS-1:0]  range_low;
    logic [WIDTH_BITS-1:0]       bin_span;
    logic [RESC_BITS-1:0]        rescale_count;
  } auh_out_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_CLEAR,
    OP_RESCALE,
    OP_MERGE_HI,
    OP_MERGE_LO,
    OP_RD0,
    OP_RD1,
    OP_WR,
    OP_MERGE_END,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_BIN_RD,
    OP_BIN_WR,
    OP_READ_RD,
    OP_READ_CAP,
    OP_OUT
  } auh_op_t;

  typedef struct packed {
    auh_op_t op;
  } auh_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       need_scale;
    logic       can_low;
    logic       can_high;
    logic       merge_last;
    logic       div_last;
    logic       out_busy;
  } auh_stat_t;

endpackage

// ===== design/auh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module auh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/auh_ctrl.sv =====
// Request sequencer: accepts one transaction; on an add, steps the datapath
// through rescale, merge, divide, bin update; posts the result. Uses auh_pkg.
module auh_ctrl
  import auh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  auh_stat_t stat,
  output auh_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCALE, S_M_RD0, S_M_RD1, S_M_WR, S_M_END,
    S_DIV, S_BIN_RD, S_BIN_WR, S_READ_CAP, S_FIN
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.req)
          REQ_ADD: begin
            cmd.op     = OP_RESCALE;
            state_next = S_SCALE;
          end
          REQ_READ: begin
            cmd.op     = OP_READ_RD;
            state_next = S_READ_CAP;
          end
          REQ_CLEAR: begin
            cmd.op     = OP_CLEAR;
            state_next = S_FIN;
          end
          default: state_next = S_FIN;
        endcase
      end
      S_SCALE: begin
        if (stat.can_low) begin
          cmd.op     = OP_MERGE_HI;
          state_next = S_M_RD0;
        end else if (stat.can_high) begin
          cmd.op     = OP_MERGE_LO;
          state_next = S_M_RD0;
        end else begin
          cmd.op     = OP_DIV_INIT;
          state_next = S_DIV;
        end
      end
      S_M_RD0: begin
        cmd.op     = OP_RD0;
        state_next = S_M_RD1;
      end
      S_M_RD1: begin
        cmd.op     = OP_RD1;
        state_next = S_M_WR;
      end
      S_M_WR: begin
        cmd.op     = OP_WR;
        state_next = stat.merge_last ? S_M_END : S_M_RD0;
      end
      S_M_END: begin
        cmd.op     = OP_MERGE_END;
        state_next = S_SCALE;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_last) begin
          state_next = S_BIN_RD;
        end
      end
      S_BIN_RD: begin
        cmd.op     = OP_BIN_RD;
        state_next = S_BIN_WR;
      end
      S_BIN_WR: begin
        cmd.op     = OP_BIN_WR;
        state_next = S_FIN;
      end
      S_READ_CAP: begin
        cmd.op     = OP_READ_CAP;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/auh_dp.sv =====
// Datapath: range registers, bin store with valid bits, pair merger,
// restoring divider for the bin index and the result register. Uses auh_pkg, auh_ram.
module auh_dp
  import auh_pkg::*;
#(
  parameter int N_BINS      = 64,
  parameter int COUNT_BITS  = 32,
  parameter int SAMPLE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  auh_cmd_t           cmd,
  output auh_stat_t          stat,
  input  auh_in_t            in_data,
  input  logic signed [31:0] start_low,
  input  logic [31:0]        start_width,
  input  logic               auto_scale,
  output logic               out_valid,
  input  logic               out_ready,
  output auh_out_t           out_data
);

  localparam int NB   = 2 * ((N_BINS + 1) / 2);
  localparam int IDXW = $clog2(NB);
  localparam int KW   = (NB / 2 > 1) ? $clog2(NB / 2) : 1;
  localparam int DCW  = (IDXW > 1) ? $clog2(IDXW) : 1;
  localparam int RW   = WIDTH_BITS + IDXW;
  localparam int EW   = (IDXW + 45 > 49) ? IDXW + 45 : 49;
  localparam int IW6  = (IDXW > 6) ? IDXW : 6;
  localparam int CW   = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam int SH   = LOW_BITS - SAMPLE_BITS;
  localparam logic [IDXW-1:0] NB_M1 = IDXW'(NB - 1);
  localparam logic [IDXW-1:0] NB_M2 = IDXW'(NB - 2);

  logic [1:0]                 req_q;
  logic signed [EW-1:0]       s_q;
  logic [IDXW-1:0]            ridx_q;
  logic                       rd_ok;
  logic signed [LOW_BITS-1:0] lo;
  logic [WIDTH_BITS-1:0]      w;
  logic [RW-1:0]              range_q;
  logic [RESC_BITS-1:0]       resc;
  logic [KW-1:0]              k;
  logic                       dir_hi;
  logic [COUNT_BITS-1:0]      d0;
  logic [IDXW-1:0]            raddr_q;
  logic [NB-1:0]              vld;
  logic [RW-1:0]              rem, dv;
  logic [IDXW-1:0]            q;
  logic [DCW-1:0]             dcnt;
  logic                       clamp_lo, clamp_hi;
  logic [5:0]                 idx6;
  logic [COUNT_BITS-1:0]      cnt_q;

  logic [COUNT_BITS-1:0]      rdata, rdata_eff, merged, incd;
  logic [COUNT_BITS:0]        sum;
  logic [IDXW-1:0]            raddr, waddr, k2, src0, src1, dst, bsel;
  logic                       we;
  logic [COUNT_BITS-1:0]      wdata;
  logic signed [EW-1:0]       lo_e, rng_e, hi_e, lo_dn, lmin;
  logic                       below, above, wide_stop;
  logic [31:0]                wsel;
  logic [LOW_BITS-1:0]        sz;
  logic signed [LOW_BITS-1:0] ssx;
  logic [IW6-1:0]             bext;
  logic [CW-1:0]              cext;

  auh_ram #(.WIDTH(COUNT_BITS), .DEPTH(NB)) u_bins (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entries cleared or freed by a merge read back as zero
  assign rdata_eff = vld[raddr_q] ? rdata : '0;

  assign lo_e      = EW'(lo);
  assign rng_e     = $signed(EW'(range_q));
  assign hi_e      = lo_e + rng_e;
  assign lo_dn     = lo_e - rng_e;
  assign lmin      = EW'(LOW_MIN);
  assign below     = s_q < lo_e;
  assign above     = s_q >= hi_e;
  assign wide_stop = w > WIDTH_HALF;

  assign stat.req        = req_q;
  assign stat.need_scale = auto_scale && (below || above);
  assign stat.can_low    = auto_scale && below && !wide_stop && !(lo_dn < lmin);
  assign stat.can_high   = auto_scale && !below && above && !wide_stop;
  assign stat.merge_last = (k == KW'(NB / 2 - 1));
  assign stat.div_last   = (dcnt == '0);
  assign stat.out_busy   = out_valid && !out_ready;

  assign k2   = IDXW'({k, 1'b0});
  assign src0 = dir_hi ? NB_M2 - k2 : k2;
  assign src1 = dir_hi ? NB_M1 - k2 : k2 + IDXW'(1);
  assign dst  = dir_hi ? NB_M1 - IDXW'(k) : IDXW'(k);
  assign bsel = clamp_lo ? '0 : (clamp_hi ? NB_M1 : q);

  assign sum    = {1'b0, d0} + {1'b0, rdata_eff};
  assign merged = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  assign incd   = (rdata_eff == '1) ? rdata_eff : rdata_eff + COUNT_BITS'(1);

  assign wsel = (start_width == '0) ? 32'd1 : start_width;
  assign sz   = {16'h0, in_data.sample};
  assign ssx  = $signed(sz << SH) >>> SH;
  assign bext = IW6'(bsel);
  assign cext = CW'(cnt_q);

  always_comb begin
    raddr = src0;
    we    = 1'b0;
    waddr = dst;
    wdata = merged;
    case (cmd.op)
      OP_RD1:     raddr = src1;
      OP_BIN_RD:  raddr = bsel;
      OP_READ_RD: raddr = ridx_q;
      OP_WR:      we = 1'b1;
      OP_BIN_WR: begin
        we    = 1'b1;
        waddr = bsel;
        wdata = incd;
      end
      default: raddr = src0;
    endcase
  end

  always_ff @(posedge clk) begin
    raddr_q <= raddr;
    if (rst) begin
      vld       <= '0;
      lo        <= LOW_BITS'(START_LOW_RST);
      w         <= WIDTH_BITS'(START_WIDTH_RST);
      range_q   <= RW'(NB);
      resc      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && cmd.op != OP_OUT) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          req_q  <= in_data.req_type;
          s_q    <= EW'(ssx);
          ridx_q <= IDXW'(in_data.read_index);
          rd_ok  <= 32'(in_data.read_index) < 32'(NB);
          idx6   <= (in_data.req_type == REQ_READ) ? in_data.read_index : 6'd0;
          cnt_q  <= '0;
        end
        OP_CLEAR: begin
          vld     <= '0;
          lo      <= LOW_BITS'(start_low);
          w       <= WIDTH_BITS'(wsel);
          range_q <= RW'(wsel) * RW'(NB);
          resc    <= '0;
        end
        OP_RESCALE: begin
          if (stat.need_scale && resc != '1) begin
            resc <= resc + RESC_BITS'(1);
          end
        end
        OP_MERGE_HI: begin
          dir_hi <= 1'b1;
          k      <= '0;
        end
        OP_MERGE_LO: begin
          dir_hi <= 1'b0;
          k      <= '0;
        end
        OP_RD1: d0 <= rdata_eff;
        OP_WR: begin
          vld[dst] <= 1'b1;
          k        <= k + KW'(1);
        end
        OP_MERGE_END: begin
          for (int i = 0; i < NB; i++) begin
            if ((i < NB / 2) == dir_hi) begin
              vld[i] <= 1'b0;
            end
          end
          if (dir_hi) begin
            lo <= LOW_BITS'(lo_dn);
          end
          w       <= w << 1;
          range_q <= range_q << 1;
        end
        OP_DIV_INIT: begin
          rem      <= RW'(s_q - lo_e);
          dv       <= RW'(w) << (IDXW - 1);
          q        <= '0;
          dcnt     <= DCW'(IDXW - 1);
          clamp_lo <= below;
          clamp_hi <= above;
        end
        OP_DIV_STEP: begin
          if (rem >= dv) begin
            rem <= rem - dv;
          end
          q    <= IDXW'({q, rem >= dv});
          dv   <= dv >> 1;
          dcnt <= dcnt - DCW'(1);
        end
        OP_BIN_WR: begin
          vld[bsel] <= 1'b1;
          cnt_q     <= incd;
          idx6      <= bext[5:0];
        end
        OP_READ_CAP: cnt_q <= rd_ok ? rdata_eff : '0;
        OP_OUT: begin
          out_valid              <= 1'b1;
          out_data.bin_index     <= idx6;
          out_data.bin_count     <= cext[31:0];
          out_data.range_low     <= lo;
          out_data.bin_span      <= w;
          out_data.rescale_count <= resc;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/autoscaling_uniform_histogram.sv =====
// Top level of the autoscaling uniform histogram: APB register file,
// controller and datapath. Uses auh_pkg, auh_ctrl, auh_dp.

// Keeps NB = N_BINS rounded up to even saturating bin counters over a range
// that doubles toward outlying samples when auto_scale is set. One request at a
// time. An add forms the bin index with the one-bit-per-cycle restoring divider,
// and each doubling runs a pair merge through the single read port of the bin
// RAM. Reset and clear take effect at once through per-bin valid bits. A
// finished result waits in an output register.
module autoscaling_uniform_histogram
  import auh_pkg::*;
#(
  parameter int N_BINS      = 64,
  parameter int COUNT_BITS  = 32,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  auh_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output auh_out_t             out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic signed [31:0] start_low;
  logic [31:0]        start_width;
  logic               auto_scale;
  logic [1:0]         reg_idx;
  auh_cmd_t           cmd;
  auh_stat_t          stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_low   <= START_LOW_RST;
      start_width <= START_WIDTH_RST;
      auto_scale  <= AUTO_SCALE_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_START_LOW:   start_low   <= pwdata;
        REG_START_WIDTH: start_width <= pwdata;
        REG_AUTO_SCALE:  auto_scale  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_LOW:   prdata = start_low;
      REG_START_WIDTH: prdata = start_width;
      REG_AUTO_SCALE:  prdata = {31'h0, auto_scale};
      default:         prdata = '0;
    endcase
  end

  auh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  auh_dp #(
    .N_BINS      (N_BINS),
    .COUNT_BITS  (COUNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_data     (in_data),
    .start_low   (start_low),
    .start_width (start_width),
    .auto_scale  (auto_scale),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

`ifndef SYNTH
  // one transaction in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new transaction taken while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT |-> !(out_valid && !out_ready))
    else $error("result register overwritten");

  a_width_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.bin_span != '0)
    else $error("bin width is zero");
`endif

endmodule
